@@ hw/rtl/tlb_pkg.sv @@
// ----------------------------------------------------------------------------
// tlb_pkg
// shared types, constants and arithmetic helpers for the 3d lut blend block
// ----------------------------------------------------------------------------
package tlb_pkg;

   localparam int LUT_MAX_DIM = 33;
   localparam int CH_W        = 12;
   localparam int SIZE_W      = 6;
   localparam int STR_W       = 9;
   localparam int IDX_W       = 16;
   localparam int ENTRY_W     = 3 * CH_W;
   localparam int CORNERS     = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_LUT_SIZE       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLEND_STRENGTH = 2'd1;

   localparam logic [12:0] CH_MAX13 = 13'd4095;

   typedef logic [2:0][CH_W-1:0] rgb_type;

   typedef struct packed {
      logic    valid;
      logic    load;
      logic    pass;
      rgb_type pix;
   } ctl_type;

   function automatic logic [CH_W-1:0] lerp12(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b,
                                              input logic [CH_W-1:0] f);
      logic [24:0] s;
      s = 25'(a) * 25'(13'd4096 - 13'(f)) + 25'(b) * 25'(f) + 25'd2048;
      return s[23:12];
   endfunction

   function automatic logic [CH_W-1:0] blend12(input logic [CH_W-1:0]  p,
                                               input logic [CH_W-1:0]  t,
                                               input logic [STR_W-1:0] s);
      logic signed [25:0] v;
      logic signed [25:0] q;
      v = $signed({14'b0, p}) * 26'sd256
        + ($signed({14'b0, t}) - $signed({14'b0, p})) * $signed({17'b0, s})
        + 26'sd128;
      q = v >>> 8;
      if (v < 0) begin
         return '0;
      end else if (q > 26'sd4095) begin
         return 12'd4095;
      end else begin
         return q[CH_W-1:0];
      end
   endfunction

endpackage

@@ hw/rtl/tlb_if.sv @@
// ----------------------------------------------------------------------------
// tlb channel interfaces
// request, response and register write channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface tlb_req_if;
   logic                         valid;
   logic                         ready;
   logic                         req_type;
   logic [tlb_pkg::IDX_W-1:0]    entry_index;
   logic [tlb_pkg::CH_W-1:0]     entry_red;
   logic [tlb_pkg::CH_W-1:0]     entry_green;
   logic [tlb_pkg::CH_W-1:0]     entry_blue;
   logic [tlb_pkg::CH_W-1:0]     pixel_red;
   logic [tlb_pkg::CH_W-1:0]     pixel_green;
   logic [tlb_pkg::CH_W-1:0]     pixel_blue;

   modport source (output valid, req_type, entry_index, entry_red, entry_green, entry_blue,
                   pixel_red, pixel_green, pixel_blue, input ready);
   modport sink   (input valid, req_type, entry_index, entry_red, entry_green, entry_blue,
                   pixel_red, pixel_green, pixel_blue, output ready);
endinterface

interface tlb_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [tlb_pkg::CH_W-1:0] out_red;
   logic [tlb_pkg::CH_W-1:0] out_green;
   logic [tlb_pkg::CH_W-1:0] out_blue;

   modport source (output valid, out_red, out_green, out_blue, input ready);
   modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

interface tlb_csr_if;
   logic                           valid;
   logic                           ready;
   logic [tlb_pkg::CSR_IDX_W-1:0]  index;
   logic [tlb_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/trilinear_color_lut_blend_top.sv @@
// ----------------------------------------------------------------------------
// trilinear_color_lut_blend_top
// 3d color lut with trilinear interpolation and strength blend
// ----------------------------------------------------------------------------
// Takes one item per clock, load or pixel, while the output skid register is
// empty, and returns one result per pixel item, in order. The rate is set by
// the table, which is kept as eight identical copies so that all eight
// corners of a pixel are read in the same cycle; a load item writes the
// same entry into every copy. Table contents are undefined until loaded and
// there is no clearing pass. An output skid register decouples rsp ready
// from req ready. The user must write registers through csr_ch only while
// the block is idle; the block itself does not enforce this.
module trilinear_color_lut_blend_top #(
   parameter int LUT_MAX_DIM = tlb_pkg::LUT_MAX_DIM
) (
   input  logic      clock,
   input  logic      reset,
   tlb_req_if.sink   req_ch,
   tlb_rsp_if.source rsp_ch,
   tlb_csr_if.sink   csr_ch
);

   localparam int DEPTH  = LUT_MAX_DIM * LUT_MAX_DIM * LUT_MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [tlb_pkg::SIZE_W-1:0] size_ff;
   logic [tlb_pkg::STR_W-1:0]  strength_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff     <= '0;
         strength_ff <= '0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            tlb_pkg::CSR_LUT_SIZE:       size_ff     <= csr_ch.data[tlb_pkg::SIZE_W-1:0];
            tlb_pkg::CSR_BLEND_STRENGTH: strength_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   logic advance;
   logic skid_v_ff;
   logic out_v_ff;

   assign advance      = !skid_v_ff;
   assign req_ch.ready = advance;

   tlb_pkg::ctl_type                            d_ctl;
   logic [tlb_pkg::CORNERS-1:0][ADDR_W-1:0]     d_addr;
   tlb_pkg::rgb_type                            d_frac;
   logic                                        d_wr;
   logic [ADDR_W-1:0]                           d_wr_addr;
   logic [tlb_pkg::ENTRY_W-1:0]                 d_wr_data;
   logic [tlb_pkg::CORNERS-1:0][tlb_pkg::ENTRY_W-1:0] corner;

   tlb_index #(
      .LUT_MAX_DIM (LUT_MAX_DIM),
      .ADDR_W      (ADDR_W)
   ) u_index (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (req_ch.valid),
      .in_load      (!req_ch.req_type),
      .in_index     (req_ch.entry_index),
      .in_entry     ({req_ch.entry_blue, req_ch.entry_green, req_ch.entry_red}),
      .in_pix       ({req_ch.pixel_blue, req_ch.pixel_green, req_ch.pixel_red}),
      .cfg_size     (size_ff),
      .cfg_strength (strength_ff),
      .d_ctl        (d_ctl),
      .d_addr       (d_addr),
      .d_frac       (d_frac),
      .d_wr         (d_wr),
      .d_wr_addr    (d_wr_addr),
      .d_wr_data    (d_wr_data)
   );

   for (genvar k = 0; k < tlb_pkg::CORNERS; k++) begin : g_bank
      tlb_ram #(
         .WIDTH (tlb_pkg::ENTRY_W),
         .DEPTH (DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (advance && d_wr),
         .wr_addr (d_wr_addr),
         .wr_data (d_wr_data),
         .rd_en   (advance),
         .rd_addr (d_addr[k]),
         .rd_data (corner[k])
      );
   end

   logic             p_valid;
   tlb_pkg::rgb_type p_rgb;

   tlb_interp u_interp (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .d_ctl        (d_ctl),
      .d_frac       (d_frac),
      .corner       (corner),
      .cfg_strength (strength_ff),
      .p_valid      (p_valid),
      .p_rgb        (p_rgb)
   );

   // output register plus skid register
   tlb_pkg::rgb_type out_ff;
   tlb_pkg::rgb_type skid_ff;
   logic             push;
   logic             hold;

   assign push = advance && p_valid;
   assign hold = out_v_ff && !rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (hold) begin
         if (push) begin
            skid_v_ff <= 1'b1;
         end
      end else if (skid_v_ff) begin
         out_v_ff  <= 1'b1;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff <= push;
      end
   end

   always_ff @(posedge clock) begin
      if (hold) begin
         if (push) begin
            skid_ff <= p_rgb;
         end
      end else if (skid_v_ff) begin
         out_ff <= skid_ff;
      end else begin
         out_ff <= p_rgb;
      end
   end

   assign rsp_ch.valid     = out_v_ff;
   assign rsp_ch.out_red   = out_ff[0];
   assign rsp_ch.out_green = out_ff[1];
   assign rsp_ch.out_blue  = out_ff[2];

   a_skid_needs_out : assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid holds an item while the output register is empty");

   a_skid_drains : assert property (@(posedge clock) disable iff (reset)
      (skid_v_ff && rsp_ch.ready) |=> (!skid_v_ff && out_v_ff))
      else $error("skid item was not moved to the output register");

   a_no_spurious_skid : assert property (@(posedge clock) disable iff (reset)
      (!skid_v_ff && (!out_v_ff || rsp_ch.ready)) |=> !skid_v_ff)
      else $error("skid filled without an output stall");

endmodule

@@ hw/rtl/tlb_ram.sv @@
// ----------------------------------------------------------------------------
// tlb_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module tlb_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

@@ hw/rtl/tlb_index.sv @@
// ----------------------------------------------------------------------------
// tlb_index
// front pipeline: grid scaling, corner coordinates and table addresses
// ----------------------------------------------------------------------------
module tlb_index #(
   parameter int LUT_MAX_DIM = tlb_pkg::LUT_MAX_DIM,
   parameter int ADDR_W      = $clog2(LUT_MAX_DIM * LUT_MAX_DIM * LUT_MAX_DIM)
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         advance,
   input  logic                                         in_valid,
   input  logic                                         in_load,
   input  logic [tlb_pkg::IDX_W-1:0]                    in_index,
   input  logic [tlb_pkg::ENTRY_W-1:0]                  in_entry,
   input  tlb_pkg::rgb_type                             in_pix,
   input  logic [tlb_pkg::SIZE_W-1:0]                   cfg_size,
   input  logic [tlb_pkg::STR_W-1:0]                    cfg_strength,
   output tlb_pkg::ctl_type                             d_ctl,
   output logic [tlb_pkg::CORNERS-1:0][ADDR_W-1:0]      d_addr,
   output tlb_pkg::rgb_type                             d_frac,
   output logic                                         d_wr,
   output logic [ADDR_W-1:0]                            d_wr_addr,
   output logic [tlb_pkg::ENTRY_W-1:0]                  d_wr_data
);

   localparam int         DEPTH = LUT_MAX_DIM * LUT_MAX_DIM * LUT_MAX_DIM;
   localparam logic [6:0] MAX7  = 7'(LUT_MAX_DIM);

   logic [tlb_pkg::SIZE_W-1:0] sz;
   logic [tlb_pkg::SIZE_W-1:0] sz_m1;
   logic [11:0]                sz2_ff;

   assign sz    = (7'(cfg_size) > MAX7) ? MAX7[tlb_pkg::SIZE_W-1:0] : cfg_size;
   assign sz_m1 = sz - 6'd1;

   always_ff @(posedge clock) begin
      sz2_ff <= 12'(sz) * 12'(sz);
   end

   // stage a: capture
   tlb_pkg::ctl_type            a_ctl_ff;
   logic [tlb_pkg::IDX_W-1:0]   a_idx_ff;
   logic [tlb_pkg::ENTRY_W-1:0] a_wdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff <= '0;
      end else if (advance) begin
         a_ctl_ff.valid <= in_valid;
         a_ctl_ff.load  <= in_load;
         a_ctl_ff.pass  <= (sz <= 6'd1) || (cfg_strength == '0);
         a_ctl_ff.pix   <= in_pix;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_idx_ff   <= in_index;
         a_wdata_ff <= in_entry;
      end
   end

   // stage b: scale by size-1
   tlb_pkg::ctl_type            b_ctl_ff;
   logic [2:0][17:0]            b_sc_ff;
   logic                        b_wr_ff;
   logic [19:0]                 b_idx_ff;
   logic [tlb_pkg::ENTRY_W-1:0] b_wdata_ff;
   logic [19:0]                 a_idx_ext;

   assign a_idx_ext = 20'(a_idx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ctl_ff <= '0;
         b_wr_ff  <= 1'b0;
      end else if (advance) begin
         b_ctl_ff <= a_ctl_ff;
         b_wr_ff  <= a_ctl_ff.valid && a_ctl_ff.load && (a_idx_ext < 20'(DEPTH));
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            b_sc_ff[k] <= 18'(a_ctl_ff.pix[k]) * 18'(sz_m1);
         end
         b_idx_ff   <= a_idx_ext;
         b_wdata_ff <= a_wdata_ff;
      end
   end

   // stage c: lower/upper corner and fraction
   tlb_pkg::ctl_type                 c_ctl_ff;
   logic [2:0][tlb_pkg::SIZE_W-1:0]  c_lo_ff;
   logic [2:0][tlb_pkg::SIZE_W-1:0]  c_hi_ff;
   tlb_pkg::rgb_type                 c_fr_ff;
   logic                             c_wr_ff;
   logic [19:0]                      c_idx_ff;
   logic [tlb_pkg::ENTRY_W-1:0]      c_wdata_ff;
   logic [2:0][tlb_pkg::SIZE_W-1:0]  lo_in;
   logic [2:0][tlb_pkg::SIZE_W-1:0]  hi_in;
   tlb_pkg::rgb_type                 fr_in;

   always_comb begin
      logic [tlb_pkg::SIZE_W-1:0] q;
      logic [12:0]                r;
      for (int k = 0; k < 3; k++) begin
         q = b_sc_ff[k][17:12];
         r = {1'b0, b_sc_ff[k][11:0]} + 13'(q);
         if (r >= tlb_pkg::CH_MAX13) begin
            lo_in[k] = q + 6'd1;
            fr_in[k] = 12'(r - tlb_pkg::CH_MAX13);
         end else begin
            lo_in[k] = q;
            fr_in[k] = r[11:0];
         end
         hi_in[k] = ((7'(lo_in[k]) + 7'd1) < 7'(sz)) ? lo_in[k] + 6'd1 : sz_m1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ctl_ff <= '0;
         c_wr_ff  <= 1'b0;
      end else if (advance) begin
         c_ctl_ff <= b_ctl_ff;
         c_wr_ff  <= b_wr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c_lo_ff    <= lo_in;
         c_hi_ff    <= hi_in;
         c_fr_ff    <= fr_in;
         c_idx_ff   <= b_idx_ff;
         c_wdata_ff <= b_wdata_ff;
      end
   end

   // stage d: linear addresses of the eight corners
   logic [tlb_pkg::CORNERS-1:0][ADDR_W-1:0] addr_in;

   always_comb begin
      logic [tlb_pkg::SIZE_W-1:0] ri;
      logic [tlb_pkg::SIZE_W-1:0] gi;
      logic [tlb_pkg::SIZE_W-1:0] bi;
      logic [18:0]                sum;
      for (int k = 0; k < tlb_pkg::CORNERS; k++) begin
         ri  = k[0] ? c_hi_ff[0] : c_lo_ff[0];
         gi  = k[1] ? c_hi_ff[1] : c_lo_ff[1];
         bi  = k[2] ? c_hi_ff[2] : c_lo_ff[2];
         sum = 19'(bi) * 19'(sz2_ff) + 19'(gi) * 19'(sz) + 19'(ri);
         addr_in[k] = sum[ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ctl <= '0;
         d_wr  <= 1'b0;
      end else if (advance) begin
         d_ctl <= c_ctl_ff;
         d_wr  <= c_wr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_addr    <= addr_in;
         d_frac    <= c_fr_ff;
         d_wr_addr <= c_idx_ff[ADDR_W-1:0];
         d_wr_data <= c_wdata_ff;
      end
   end

endmodule

@@ hw/rtl/tlb_interp.sv @@
// ----------------------------------------------------------------------------
// tlb_interp
// back pipeline: red, green and blue axis interpolation, then strength blend
// ----------------------------------------------------------------------------
module tlb_interp (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          advance,
   input  tlb_pkg::ctl_type                              d_ctl,
   input  tlb_pkg::rgb_type                              d_frac,
   input  logic [tlb_pkg::CORNERS-1:0][tlb_pkg::ENTRY_W-1:0] corner,
   input  logic [tlb_pkg::STR_W-1:0]                     cfg_strength,
   output logic                                          p_valid,
   output tlb_pkg::rgb_type                              p_rgb
);

   // stage e: aligned with table read data
   tlb_pkg::ctl_type e_ctl_ff;
   tlb_pkg::rgb_type e_fr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_ctl_ff <= '0;
      end else if (advance) begin
         e_ctl_ff <= d_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         e_fr_ff <= d_frac;
      end
   end

   // stage f: red axis
   tlb_pkg::ctl_type                      f_ctl_ff;
   tlb_pkg::rgb_type                      f_fr_ff;
   logic [2:0][3:0][tlb_pkg::CH_W-1:0]    f_val_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_ctl_ff <= '0;
      end else if (advance) begin
         f_ctl_ff <= e_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f_fr_ff <= e_fr_ff;
         for (int ch = 0; ch < 3; ch++) begin
            for (int j = 0; j < 4; j++) begin
               f_val_ff[ch][j] <= tlb_pkg::lerp12(corner[2*j][12*ch +: 12],
                                                  corner[2*j+1][12*ch +: 12], e_fr_ff[0]);
            end
         end
      end
   end

   // stage g: green axis
   tlb_pkg::ctl_type                      g_ctl_ff;
   logic [tlb_pkg::CH_W-1:0]              g_fr_ff;
   logic [2:0][1:0][tlb_pkg::CH_W-1:0]    g_val_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         g_ctl_ff <= '0;
      end else if (advance) begin
         g_ctl_ff <= f_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         g_fr_ff <= f_fr_ff[2];
         for (int ch = 0; ch < 3; ch++) begin
            for (int j = 0; j < 2; j++) begin
               g_val_ff[ch][j] <= tlb_pkg::lerp12(f_val_ff[ch][2*j], f_val_ff[ch][2*j+1],
                                                  f_fr_ff[1]);
            end
         end
      end
   end

   // stage h: blue axis
   tlb_pkg::ctl_type h_ctl_ff;
   tlb_pkg::rgb_type h_res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ctl_ff <= '0;
      end else if (advance) begin
         h_ctl_ff <= g_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int ch = 0; ch < 3; ch++) begin
            h_res_ff[ch] <= tlb_pkg::lerp12(g_val_ff[ch][0], g_val_ff[ch][1], g_fr_ff);
         end
      end
   end

   // stage p: blend and saturate
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid <= 1'b0;
      end else if (advance) begin
         p_valid <= h_ctl_ff.valid && !h_ctl_ff.load;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int ch = 0; ch < 3; ch++) begin
            p_rgb[ch] <= h_ctl_ff.pass ? h_ctl_ff.pix[ch]
                       : tlb_pkg::blend12(h_ctl_ff.pix[ch], h_res_ff[ch], cfg_strength);
         end
      end
   end

endmodule

@@ test/tlb_blend_checker.sv @@
// ----------------------------------------------------------------------------
// tlb_blend_checker
// watches the register, request and response channels of the 3d lut blend
// block, keeps its own table and registers, grades every accepted pixel and
// compares each response item with the oldest graded pixel
// ----------------------------------------------------------------------------
module tlb_blend_checker (
   input  logic clock,
   input  logic reset,
   tlb_req_if   req_ch,
   tlb_rsp_if   rsp_ch,
   tlb_csr_if   csr_ch,
   output int   fail_count,
   output int   graded_pending
);

   localparam int LUT_MAX_DIM = tlb_pkg::LUT_MAX_DIM;
   localparam int CH_W        = tlb_pkg::CH_W;
   localparam int ENTRY_W     = tlb_pkg::ENTRY_W;
   localparam int SIZE_W      = tlb_pkg::SIZE_W;
   localparam int STR_W       = tlb_pkg::STR_W;
   localparam int TABLE_DEPTH = LUT_MAX_DIM * LUT_MAX_DIM * LUT_MAX_DIM;

   logic [ENTRY_W-1:0] grid_table [TABLE_DEPTH];
   logic [SIZE_W-1:0]  grid_size;
   logic [STR_W-1:0]   strength;
   logic [ENTRY_W-1:0] graded_rgb [$];

   function automatic int mix_axis(input int a, input int b, input int f);
      return (a * (4096 - f) + b * f + 2048) >>> 12;
   endfunction

   function automatic int mix_toward(input int p, input int t, input int s);
      int v;
      v = p * 256 + (t - p) * s + 128;
      if (v < 0) return 0;
      v = v / 256;
      return (v > 4095) ? 4095 : v;
   endfunction

   function automatic logic [ENTRY_W-1:0] grade_pixel(input logic [ENTRY_W-1:0] px);
      int pix [3];
      int lo [3];
      int hi [3];
      int fr [3];
      int c [8];
      int sz, sc, ri, gi, bi, c00, c10, c01, c11, c0, c1;
      logic [ENTRY_W-1:0] res;
      for (int k = 0; k < 3; k++) pix[k] = px[k*CH_W +: CH_W];
      sz = (grid_size > LUT_MAX_DIM) ? LUT_MAX_DIM : grid_size;
      if (sz <= 1 || strength == 0) return px;
      for (int k = 0; k < 3; k++) begin
         sc = pix[k] * (sz - 1);
         lo[k] = sc / 4095;
         hi[k] = (lo[k] + 1 < sz) ? lo[k] + 1 : sz - 1;
         fr[k] = ((sc % 4095) * 4096) / 4095;
      end
      for (int ch = 0; ch < 3; ch++) begin
         for (int k = 0; k < 8; k++) begin
            ri = k[0] ? hi[0] : lo[0];
            gi = k[1] ? hi[1] : lo[1];
            bi = k[2] ? hi[2] : lo[2];
            c[k] = grid_table[bi * sz * sz + gi * sz + ri][ch*CH_W +: CH_W];
         end
         c00 = mix_axis(c[0], c[1], fr[0]);
         c10 = mix_axis(c[2], c[3], fr[0]);
         c01 = mix_axis(c[4], c[5], fr[0]);
         c11 = mix_axis(c[6], c[7], fr[0]);
         c0 = mix_axis(c00, c10, fr[1]);
         c1 = mix_axis(c01, c11, fr[1]);
         res[ch*CH_W +: CH_W] = CH_W'(mix_toward(pix[ch], mix_axis(c0, c1, fr[2]), strength));
      end
      return res;
   endfunction

   task automatic report(input string field, input int got, input int want);
      $display("mismatch on %s: got %0d, expected %0d", field, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      graded_pending = 0;
   end

   always @(posedge clock) begin
      logic [ENTRY_W-1:0] want;
      if (reset) begin
         grid_size = '0;
         strength = '0;
         graded_rgb.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (graded_rgb.size() == 0) begin
               $display("response item with no pixel outstanding");
               fail_count++;
            end else begin
               want = graded_rgb.pop_front();
               if (rsp_ch.out_red !== want[0 +: CH_W])
                  report("out_red", rsp_ch.out_red, want[0 +: CH_W]);
               if (rsp_ch.out_green !== want[CH_W +: CH_W])
                  report("out_green", rsp_ch.out_green, want[CH_W +: CH_W]);
               if (rsp_ch.out_blue !== want[2*CH_W +: CH_W])
                  report("out_blue", rsp_ch.out_blue, want[2*CH_W +: CH_W]);
            end
         end
         if (csr_ch.valid && csr_ch.ready) begin
            if (csr_ch.index == tlb_pkg::CSR_LUT_SIZE)
               grid_size = csr_ch.data[SIZE_W-1:0];
            else if (csr_ch.index == tlb_pkg::CSR_BLEND_STRENGTH)
               strength = csr_ch.data;
         end
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.req_type == 1'b0) begin
               if (req_ch.entry_index < TABLE_DEPTH)
                  grid_table[req_ch.entry_index] =
                     {req_ch.entry_blue, req_ch.entry_green, req_ch.entry_red};
            end else begin
               graded_rgb.push_back(grade_pixel(
                  {req_ch.pixel_blue, req_ch.pixel_green, req_ch.pixel_red}));
            end
         end
      end
      graded_pending = graded_rgb.size();
   end

endmodule

@@ test/tb_trilinear_color_lut_blend_top.sv @@
// ----------------------------------------------------------------------------
// tb_trilinear_color_lut_blend_top
// stimulus and verdict for the 3d lut blend block: loads tables of several
// sizes, sends directed and random pixels under random gaps and response
// stalls, and leaves prediction and comparison to the checker
// ----------------------------------------------------------------------------
module tb_trilinear_color_lut_blend_top;

   localparam int LUT_MAX_DIM = tlb_pkg::LUT_MAX_DIM;
   localparam int CH_W        = tlb_pkg::CH_W;
   localparam int ENTRY_W     = tlb_pkg::ENTRY_W;
   localparam int IDX_W       = tlb_pkg::IDX_W;
   localparam int CSR_IDX_W   = tlb_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W  = tlb_pkg::CSR_DATA_W;
   localparam int TABLE_DEPTH = LUT_MAX_DIM * LUT_MAX_DIM * LUT_MAX_DIM;
   localparam int STALL_LIMIT = 3000;

   logic clock;
   logic reset;
   int   fail_count;
   int   graded_pending;
   int   idle_cycles;
   int   rsp_seen;
   bit   no_gaps;
   bit   no_stalls;

   tlb_req_if req_ch ();
   tlb_rsp_if rsp_ch ();
   tlb_csr_if csr_ch ();

   trilinear_color_lut_blend_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   tlb_blend_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_ch         (csr_ch),
      .fail_count     (fail_count),
      .graded_pending (graded_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // response side: random stalls, one long hold-off to back up the pipeline
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      rsp_seen = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = no_stalls ? 0 : $urandom_range(0, 14);
         if (rsp_seen == 120) stall = 400;
         if (stall > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         rsp_seen++;
         @(negedge clock);
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      @(negedge clock);
      csr_ch.index = idx;
      csr_ch.data = CSR_DATA_W'(value);
      csr_ch.valid = 1'b1;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic send_item(input bit is_pixel, input int idx,
                            input logic [ENTRY_W-1:0] entry, input logic [ENTRY_W-1:0] px);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 14);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.req_type = is_pixel;
      req_ch.entry_index = IDX_W'(idx);
      {req_ch.entry_blue, req_ch.entry_green, req_ch.entry_red} = entry;
      {req_ch.pixel_blue, req_ch.pixel_green, req_ch.pixel_red} = px;
      req_ch.valid = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   function automatic logic [CH_W-1:0] pick_channel();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 12'd4095;
         default: return CH_W'($urandom);
      endcase
   endfunction

   function automatic logic [ENTRY_W-1:0] pick_rgb();
      return {pick_channel(), pick_channel(), pick_channel()};
   endfunction

   task automatic load_grid(input int sz);
      for (int i = 0; i < sz * sz * sz; i++) send_item(1'b0, i, pick_rgb(), '0);
   endtask

   // only the lowest cell of a large grid, for pixels that stay inside it
   task automatic load_low_cell(input int sz);
      for (int k = 0; k < 8; k++)
         send_item(1'b0, k[2] * sz * sz + k[1] * sz + k[0], pick_rgb(), '0);
   endtask

   task automatic low_pixels(input int count);
      for (int i = 0; i < count; i++)
         send_item(1'b1, $urandom, '0, {CH_W'($urandom_range(0, 127)),
                                         CH_W'($urandom_range(0, 127)),
                                         CH_W'($urandom_range(0, 127))});
   endtask

   task automatic settle();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (graded_pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic random_pixels(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) == 0) no_gaps = ~no_gaps;
         case ($urandom_range(0, 11))
            0: send_item(1'b0, $urandom_range(TABLE_DEPTH, 65535), pick_rgb(), pick_rgb());
            1: send_item(1'b0, $urandom_range(0, 7), pick_rgb(), pick_rgb());
            default: send_item(1'b1, $urandom, pick_rgb(), pick_rgb());
         endcase
      end
   endtask

   initial begin
      int sizes [4] = '{2, 3, 5, 4};
      int strengths [4] = '{256, 1, 128, 511};
      no_gaps = 1'b0;
      no_stalls = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.req_type = 1'b0;
      req_ch.entry_index = '0;
      {req_ch.entry_red, req_ch.entry_green, req_ch.entry_blue} = '0;
      {req_ch.pixel_red, req_ch.pixel_green, req_ch.pixel_blue} = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = tlb_pkg::CSR_LUT_SIZE;
      csr_ch.data = '0;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // passthrough at reset values, then directed corners on a 2-point grid
      send_item(1'b1, 0, '0, {12'd4095, 12'd0, 12'd4095});
      send_item(1'b1, 0, '0, {12'd0, 12'd4095, 12'd0});
      settle();
      write_reg(tlb_pkg::CSR_LUT_SIZE, 2);
      write_reg(tlb_pkg::CSR_BLEND_STRENGTH, 256);
      for (int i = 0; i < 8; i++)
         send_item(1'b0, i, (i % 2) ? {36{1'b1}} : {12'd2048, 12'd4095, 12'd0}, '0);
      send_item(1'b0, 65535, {36{1'b1}}, '0);
      send_item(1'b0, TABLE_DEPTH, {36{1'b1}}, '0);
      send_item(1'b1, 0, '0, '0);
      send_item(1'b1, 0, '0, {36{1'b1}});
      send_item(1'b1, 0, '0, {12'd2048, 12'd1, 12'd4094});
      send_item(1'b1, 0, '0, {12'd2730, 12'd1365, 12'd2047});
      settle();
      write_reg(tlb_pkg::CSR_BLEND_STRENGTH, 511);
      send_item(1'b1, 0, '0, {12'd100, 12'd4000, 12'd2048});
      send_item(1'b1, 0, '0, {12'd4095, 12'd0, 12'd3000});
      settle();
      write_reg(tlb_pkg::CSR_BLEND_STRENGTH, 0);
      send_item(1'b1, 0, '0, {12'd1234, 12'd4095, 12'd7});
      settle();
      write_reg(tlb_pkg::CSR_BLEND_STRENGTH, 64);
      write_reg(tlb_pkg::CSR_LUT_SIZE, 1);
      send_item(1'b1, 0, '0, {12'd555, 12'd0, 12'd4095});
      settle();

      for (int ph = 0; ph < 4; ph++) begin
         write_reg(tlb_pkg::CSR_LUT_SIZE, sizes[ph]);
         write_reg(tlb_pkg::CSR_BLEND_STRENGTH, strengths[ph]);
         no_gaps = (sizes[ph] > 3);
         load_grid(sizes[ph]);
         no_stalls = (ph == 2);
         no_gaps = 1'b0;
         random_pixels(55);
         settle();
         no_stalls = 1'b0;
      end

      // size above the maximum is clamped; pixels stay in the lowest cell
      write_reg(tlb_pkg::CSR_LUT_SIZE, 63);
      write_reg(tlb_pkg::CSR_BLEND_STRENGTH, 200);
      load_low_cell(LUT_MAX_DIM);
      low_pixels(40);
      settle();

      write_reg(tlb_pkg::CSR_LUT_SIZE, 0);
      random_pixels(20);
      settle();

      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
